/* rtl/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// ffba_pkg: shared types and codes for the first-fit block allocator
// Status codes, command codes, heap geometry and the sequencer state type.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ZERO    = 3'd1;
  localparam logic [2:0] ST_NOFIT   = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;

  // The address and size widths are fixed by the heap size.
  localparam int HEAP_BYTES = 131072;
  localparam int ADDR_W = 17;
  localparam int SIZE_W = 18;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

/* rtl/ffba_cell.sv */
// ----------------------------------------------------------------------------
// ffba_cell: one descriptor slot in the rotating table ring
// Holds base, size and used mark; passes them to its neighbour every cycle
// while the ring rotates, or loads a new descriptor at the tail.
// ----------------------------------------------------------------------------
module ffba_cell (
  input  logic                         clk,
  input  logic                         shift,
  input  logic [ffba_pkg::ADDR_W-1:0]  base_in,
  input  logic [ffba_pkg::SIZE_W-1:0]  size_in,
  input  logic                         used_in,
  output logic [ffba_pkg::ADDR_W-1:0]  base_out,
  output logic [ffba_pkg::SIZE_W-1:0]  size_out,
  output logic                         used_out
);
  import ffba_pkg::*;

  logic [ADDR_W-1:0] base_r;
  logic [SIZE_W-1:0] size_r;
  logic              used_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      base_r <= base_in;
      size_r <= size_in;
      used_r <= used_in;
    end
  end

  assign base_out = base_r;
  assign size_out = size_r;
  assign used_out = used_r;
endmodule

/* rtl/first_fit_block_allocator_unit.sv */
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit: first-fit heap allocator
// Usage: present cmd, request_size and release_address on the in_ channel
// (valid/ready). Each word yields one result word on the out_ channel
// (block_address, status). The descriptor table lives in a ring of cells;
// cell 0 is the head. A request rotates the ring through all TABLE_ENTRIES
// slots, one slot per cycle, examining each live descriptor at the head in
// table order, so the table is back in order when the pass ends.
// The result is registered and out_valid rises in S_DONE once the pass ends.
// One request is in flight at a time: a new word is accepted only after the
// result of the last one is taken. After reset the table holds one free
// block covering the heap; the ring is loaded on the first pass, as slots
// beyond the count are dead. If the receiver stalls, the result stays in
// the output register and no new word is accepted until it is taken.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_unit #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [ffba_pkg::SIZE_W-1:0]   in_request_size,
  input  logic [ffba_pkg::ADDR_W-1:0]   in_release_address,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ffba_pkg::ADDR_W-1:0]   out_block_address,
  output logic [2:0]                    out_status
);
  import ffba_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic             init_r, init_nxt;
  logic             hit_r, hit_nxt;
  logic             cmd_r;
  logic [SIZE_W-1:0] req_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic [2:0]        res_st_r, res_st_nxt;
  logic              split_r, split_nxt;
  logic [ADDR_W-1:0] split_base_r, split_base_nxt;

  logic [ADDR_W-1:0] c_base [TABLE_ENTRIES];
  logic [SIZE_W-1:0] c_size [TABLE_ENTRIES];
  logic              c_used [TABLE_ENTRIES];
  logic              shift;
  logic [ADDR_W-1:0] h_base, t_base;
  logic [SIZE_W-1:0] h_size, t_size;
  logic              h_used, t_used;
  logic              live;

  // Head descriptor, replaced by the reset block while the ring is unloaded.
  always_comb begin
    h_base = c_base[0];
    h_size = c_size[0];
    h_used = c_used[0];
    if (init_r) begin
      h_base = '0;
      h_size = (pos_r == '0) ? SIZE_W'(HEAP_BYTES) : '0;
      h_used = 1'b0;
    end
  end

  assign live = CNT_W'(pos_r) < count_r;

  genvar g;
  generate
    for (g = 0; g < TABLE_ENTRIES; g++) begin : g_ring
      if (g == TABLE_ENTRIES - 1) begin : g_tail
        ffba_cell u_cell (
          .clk(clk), .shift(shift),
          .base_in(t_base), .size_in(t_size), .used_in(t_used),
          .base_out(c_base[g]), .size_out(c_size[g]), .used_out(c_used[g]));
      end else begin : g_mid
        ffba_cell u_cell (
          .clk(clk), .shift(shift),
          .base_in(c_base[g+1]), .size_in(c_size[g+1]), .used_in(c_used[g+1]),
          .base_out(c_base[g]), .size_out(c_size[g]), .used_out(c_used[g]));
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= CNT_W'(1);
      init_r   <= 1'b1;
      pos_r    <= '0;
      hit_r    <= 1'b0;
      split_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      init_r   <= init_nxt;
      pos_r    <= pos_nxt;
      hit_r    <= hit_nxt;
      split_r  <= split_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      cmd_r  <= in_cmd;
      req_r  <= in_request_size;
      addr_r <= in_release_address;
    end
    res_addr_r   <= res_addr_nxt;
    res_st_r     <= res_st_nxt;
    split_base_r <= split_base_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    init_nxt       = init_r;
    pos_nxt        = pos_r;
    hit_nxt        = hit_r;
    split_nxt      = split_r;
    split_base_nxt = split_base_r;
    res_addr_nxt   = res_addr_r;
    res_st_nxt     = res_st_r;
    shift          = 1'b0;
    t_base         = h_base;
    t_size         = h_size;
    t_used         = h_used;
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt  = S_SCAN;
          pos_nxt    = '0;
          hit_nxt    = 1'b0;
          split_nxt  = 1'b0;
          res_addr_nxt = '0;
          res_st_nxt = (in_cmd == CMD_FREE) ? ST_UNKNOWN : ST_NOFIT;
          if (in_cmd == CMD_ALLOC && in_request_size == '0) begin
            hit_nxt    = 1'b1;
            res_st_nxt = ST_ZERO;
          end
        end
      end
      S_SCAN: begin
        shift = 1'b1;
        if (live && !hit_r) begin
          if (cmd_r == CMD_FREE) begin
            if (h_base == addr_r) begin
              t_used     = 1'b0;
              hit_nxt    = 1'b1;
              res_st_nxt = ST_OK;
            end
          end else if (!h_used) begin
            if (h_size == req_r) begin
              t_used       = 1'b1;
              hit_nxt      = 1'b1;
              res_st_nxt   = ST_OK;
              res_addr_nxt = h_base;
            end else if (h_size > req_r) begin
              hit_nxt = 1'b1;
              if (count_r >= CNT_W'(TABLE_ENTRIES)) begin
                res_st_nxt = ST_FULL;
              end else begin
                t_base         = h_base + req_r[ADDR_W-1:0];
                t_size         = h_size - req_r;
                split_nxt      = 1'b1;
                split_base_nxt = h_base;
                res_st_nxt     = ST_OK;
                res_addr_nxt   = h_base;
              end
            end
          end
        end
        // The appended descriptor lands in the first dead slot.
        if (split_r && CNT_W'(pos_r) == count_r) begin
          t_base    = split_base_r;
          t_size    = req_r;
          t_used    = 1'b1;
          split_nxt = 1'b0;
          count_nxt = count_r + CNT_W'(1);
        end
        pos_nxt = pos_r + IDX_W'(1);
        if (pos_r == IDX_W'(TABLE_ENTRIES - 1)) begin
          state_nxt = S_DONE;
          init_nxt  = 1'b0;
        end
      end
      S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_block_address = res_addr_r;
  assign out_status        = res_st_r;
endmodule

/* verif/tb_first_fit_block_allocator_unit.sv */
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator_unit: self-checking bench for the allocator
// Drives allocate and free words with random gaps, predicts every result from
// a private copy of the descriptor table and checks each result word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class alloc_scoreboard;
  localparam int HEAP  = 131072;
  localparam int SLOTS = 256;

  logic [16:0] tbl_base [SLOTS];
  logic [17:0] tbl_size [SLOTS];
  bit          tbl_used [SLOTS];
  int          tbl_count;
  logic [16:0] exp_addr_q [$];
  logic [2:0]  exp_status_q [$];
  int          errors;

  function new();
    for (int i = 0; i < SLOTS; i++) begin
      tbl_base[i] = '0;
      tbl_size[i] = '0;
      tbl_used[i] = 0;
    end
    tbl_size[0] = HEAP;
    tbl_count = 1;
    errors = 0;
  endfunction

  // Works out the result of one accepted word and updates the table copy.
  function void note_request(logic cmd, logic [17:0] req, logic [16:0] addr);
    logic [16:0] ra;
    logic [2:0]  rs;
    logic [16:0] b;
    bit          found;
    ra = '0;
    found = 0;
    if (cmd == ffba_pkg::CMD_ALLOC) begin
      rs = ffba_pkg::ST_NOFIT;
      if (req == 0) begin
        rs = ffba_pkg::ST_ZERO;
      end else begin
        for (int i = 0; i < tbl_count && !found; i++) begin
          if (!tbl_used[i] && tbl_size[i] == req) begin
            tbl_used[i] = 1;
            ra = tbl_base[i];
            rs = ffba_pkg::ST_OK;
            found = 1;
          end else if (!tbl_used[i] && tbl_size[i] > req) begin
            found = 1;
            if (tbl_count >= SLOTS) begin
              rs = ffba_pkg::ST_FULL;
            end else begin
              b = tbl_base[i];
              tbl_base[tbl_count] = b;
              tbl_size[tbl_count] = req;
              tbl_used[tbl_count] = 1;
              tbl_count++;
              tbl_base[i] = b + req[16:0];
              tbl_size[i] = tbl_size[i] - req;
              ra = b;
              rs = ffba_pkg::ST_OK;
            end
          end
        end
      end
    end else begin
      rs = ffba_pkg::ST_UNKNOWN;
      for (int i = 0; i < tbl_count && !found; i++) begin
        if (tbl_base[i] == addr) begin
          tbl_used[i] = 0;
          rs = ffba_pkg::ST_OK;
          found = 1;
        end
      end
    end
    exp_addr_q.push_back(ra);
    exp_status_q.push_back(rs);
  endfunction

  task report(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endtask

  task check_result(logic [16:0] addr, logic [2:0] status);
    logic [16:0] ea;
    logic [2:0]  es;
    if (exp_addr_q.size() == 0) begin
      report($sformatf("unexpected word addr=%0d status=%0d", addr, status));
    end else begin
      ea = exp_addr_q.pop_front();
      es = exp_status_q.pop_front();
      if (status !== es)
        report($sformatf("status got %0d want %0d", status, es));
      if (addr !== ea)
        report($sformatf("block_address got %0d want %0d", addr, ea));
    end
  endtask

  // Returns the base of some live table entry, used to aim frees.
  function logic [16:0] pick_base();
    return tbl_base[$urandom_range(0, tbl_count - 1)];
  endfunction
endclass

module tb_first_fit_block_allocator_unit;
  localparam int WATCHDOG = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_cmd;
  logic [17:0] in_request_size;
  logic [16:0] in_release_address;
  logic        out_valid;
  logic        out_ready;
  logic [16:0] out_block_address;
  logic [2:0]  out_status;

  alloc_scoreboard sb;
  bit stim_done;
  bit hold_off;
  int idle_cycles;

  first_fit_block_allocator_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_cmd(in_cmd), .in_request_size(in_request_size),
    .in_release_address(in_release_address),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_block_address(out_block_address), .out_status(out_status)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 400);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 4);
  endfunction

  // Offers one word and holds it until the block takes it.
  task automatic send_word(logic cmd, logic [17:0] req, logic [16:0] addr);
    in_valid           <= 1'b1;
    in_cmd             <= cmd;
    in_request_size    <= req;
    in_release_address <= addr;
    do @(posedge clk); while (!in_ready);
    sb.note_request(cmd, req, addr);
  endtask

  // Valid drops only when a real gap follows, so back-to-back words keep it high.
  task automatic send_gap();
    int n;
    n = gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [17:0] rand_size();
    int k;
    k = $urandom_range(0, 19);
    if (k < 12) return $urandom_range(1, 64);
    if (k < 17) return $urandom_range(1, 2048);
    if (k < 18) return $urandom_range(0, 18'h3FFFF);
    if (k < 19) return 18'(1 << $urandom_range(0, 17));
    return 0;
  endfunction

  initial begin
    logic [17:0] sz;
    rst_n = 0;
    in_valid = 0;
    in_cmd = 0;
    in_request_size = '0;
    in_release_address = '0;
    sb = new();
    stim_done = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero size, oversize, exact whole-heap fit, unknown and double frees.
    send_word(ffba_pkg::CMD_ALLOC, 18'd0, 17'h1FFFF);
    send_word(ffba_pkg::CMD_ALLOC, 18'h3FFFF, '0);
    send_word(ffba_pkg::CMD_ALLOC, 18'd131073, '0);
    send_word(ffba_pkg::CMD_ALLOC, 18'd131072, '0);
    send_word(ffba_pkg::CMD_ALLOC, 18'd1, '0);
    send_word(ffba_pkg::CMD_FREE, 18'h3FFFF, 17'd0);
    send_word(ffba_pkg::CMD_FREE, '0, 17'd0);
    send_word(ffba_pkg::CMD_FREE, '0, 17'h1FFFF);
    send_word(ffba_pkg::CMD_ALLOC, 18'd1, 17'h1FFFF);
    send_word(ffba_pkg::CMD_ALLOC, 18'd131071, '0);
    send_word(ffba_pkg::CMD_FREE, '0, 17'd1);
    send_word(ffba_pkg::CMD_ALLOC, 18'd100, '0);
    send_word(ffba_pkg::CMD_ALLOC, 18'd131071, '0);

    // Random: mostly allocations that eventually fill the table, mixed with frees
    // of live bases, with some unknown addresses mixed in.
    for (int n = 0; n < 1150; n++) begin
      if (n == 300) hold_off = 1;
      if ($urandom_range(0, 9) < 6) begin
        sz = rand_size();
        send_word(ffba_pkg::CMD_ALLOC, sz, 17'($urandom));
      end else if ($urandom_range(0, 4) == 0) begin
        send_word(ffba_pkg::CMD_FREE, 18'($urandom), 17'($urandom));
      end else begin
        send_word(ffba_pkg::CMD_FREE, 18'($urandom), sb.pick_base());
      end
      send_gap();
    end
    in_valid <= 1'b0;
    stim_done = 1;
  end

  // Receiver side: random stalls, plus one long hold-off while the sender waits.
  initial begin
    int n;
    out_ready = 0;
    hold_off = 0;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_off = 0;
      end
      n = gap_len();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_block_address, out_status);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (stim_done);
    while (sb.exp_addr_q.size() != 0 && idle_cycles < WATCHDOG) @(posedge clk);
    if (idle_cycles >= WATCHDOG) begin
      $display("Mismatches found");
    end else begin
      repeat (300) @(posedge clk);
      if (sb.errors == 0 && sb.exp_addr_q.size() == 0) begin
        $display("No mismatches found");
      end else begin
        $display("Mismatches found");
      end
    end
    $finish;
  end

  // A hang before the stimulus ends is caught here.
  initial begin
    wait (idle_cycles >= WATCHDOG && !stim_done);
    $display("Mismatches found");
    $finish;
  end
endmodule
